>>> sv/i2cm_pkg.sv
// Shared types, codes and helpers of the I2C master byte engine.
package i2cm_pkg;

	localparam int CMD_DEPTH_DEF = 2;
	localparam int RES_DEPTH_DEF = 2;

	localparam logic [15:0] HOLD_TICKS_RST = 16'd2;
	localparam logic [15:0] HIGH_TICKS_RST = 16'd1;
	localparam logic [15:0] LOW_TICKS_RST  = 16'd1;

	localparam logic [1:0] REG_HOLD_TICKS = 2'd0;
	localparam logic [1:0] REG_HIGH_TICKS = 2'd1;
	localparam logic [1:0] REG_LOW_TICKS  = 2'd2;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ADDR_NACK = 2'd1;
	localparam logic [1:0] ST_DATA_NACK = 2'd2;

	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_START_SETUP = 4'd1;
	localparam logic [3:0] PH_START_HOLD  = 4'd2;
	localparam logic [3:0] PH_BIT_LOW     = 4'd3;
	localparam logic [3:0] PH_BIT_HIGH    = 4'd4;
	localparam logic [3:0] PH_ACK_LOW     = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH    = 4'd6;
	localparam logic [3:0] PH_WAIT_DATA   = 4'd7;
	localparam logic [3:0] PH_STOP_LOW    = 4'd8;
	localparam logic [3:0] PH_STOP_SETUP  = 4'd9;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  address;
		logic [15:0] length;
		logic [7:0]  write_byte;
		logic        write_byte_valid;
		logic        sda_in;
	} cmd_t;

	typedef struct packed {
		logic        scl_out;
		logic        sda_out;
		logic        busy_res;
		logic        write_taken;
		logic [7:0]  read_byte;
		logic        read_valid;
		logic        done_res;
		logic [1:0]  status;
		logic [15:0] nack_index;
	} res_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	function automatic logic [15:0] dur(input logic [15:0] v);
		dur = (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

>>> sv/i2cm_fifo.sv
// Small register FIFO used for the command and result queues.
module i2cm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> sv/i2cm_front.sv
// Front end: accepts input beats, classifies the op and queues commands.
module i2cm_front #(
	parameter int CMD_DEPTH = i2cm_pkg::CMD_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     op,
	input  logic [7:0]     address,
	input  logic [15:0]    length,
	input  logic [7:0]     write_byte,
	input  logic           write_byte_valid,
	input  logic           sda_in,
	input  logic           cmd_pop,
	output i2cm_pkg::cmd_t cmd,
	output logic           cmd_empty
);

	i2cm_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.address          = address;
		cmd_in.length           = length;
		cmd_in.write_byte       = write_byte;
		cmd_in.write_byte_valid = write_byte_valid;
		cmd_in.sda_in           = sda_in;
		unique case (op)
			i2cm_pkg::OP_WRITE: begin
				cmd_in.kind = i2cm_pkg::KIND_WRITE;
			end
			i2cm_pkg::OP_READ: begin
				cmd_in.kind    = i2cm_pkg::KIND_READ;
				cmd_in.address = address | 8'h01;
			end
			default: begin
				cmd_in.kind = i2cm_pkg::KIND_TICK;
			end
		endcase
	end

	i2cm_fifo #(
		.WIDTH($bits(i2cm_pkg::cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd),
		.full   (full),
		.empty  (cmd_empty)
	);

endmodule

>>> sv/i2cm_engine.sv
// Back end: bus phase sequencer, advanced by one command per step.
module i2cm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cm_pkg::cfg_wr_t cfg_wr,
	input  i2cm_pkg::cmd_t    cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  logic              res_ready,
	output logic              res_push,
	output i2cm_pkg::res_t    res
);

	logic [15:0] hold_q, high_q, low_q;
	logic [3:0]  phase_q, ph_n;
	logic [15:0] tick_q, tk_n;
	logic [3:0]  bit_q, bc_n;
	logic [15:0] byte_q, by_n;
	logic [7:0]  shift_q, sh_n;
	logic [15:0] total_q, tot_n;
	logic        is_read_q, rd_n;
	logic        addr_stage_q, as_n;
	logic [1:0]  status_q, st_n;
	logic        step;

	assign step     = cmd_valid && res_ready;
	assign cmd_pop  = step;
	assign res_push = step;

	always_comb begin
		logic [15:0] tick_inc;
		logic [3:0]  bit_inc;
		logic [15:0] byte_inc;
		logic [15:0] plen;
		logic        rx;
		logic        rx_n;
		logic        bitv;
		logic        ackb;
		logic        taken;
		logic        rvalid;
		logic        done;
		ph_n     = phase_q;
		tk_n     = tick_q;
		bc_n     = bit_q;
		by_n     = byte_q;
		sh_n     = shift_q;
		tot_n    = total_q;
		rd_n     = is_read_q;
		as_n     = addr_stage_q;
		st_n     = status_q;
		taken    = 1'b0;
		rvalid   = 1'b0;
		done     = 1'b0;
		tick_inc = tick_q + 16'd1;
		bit_inc  = bit_q + 4'd1;
		byte_inc = byte_q + 16'd1;
		rx       = is_read_q && !addr_stage_q;
		unique case (phase_q)
			i2cm_pkg::PH_START_SETUP, i2cm_pkg::PH_START_HOLD,
			i2cm_pkg::PH_STOP_SETUP: plen = i2cm_pkg::dur(hold_q);
			i2cm_pkg::PH_BIT_HIGH, i2cm_pkg::PH_ACK_HIGH: plen = i2cm_pkg::dur(high_q);
			default: plen = i2cm_pkg::dur(low_q);
		endcase

		if (phase_q == i2cm_pkg::PH_IDLE) begin
			if (cmd.kind == i2cm_pkg::KIND_WRITE || cmd.kind == i2cm_pkg::KIND_READ) begin
				rd_n  = (cmd.kind == i2cm_pkg::KIND_READ);
				sh_n  = cmd.address;
				tot_n = cmd.length;
				by_n  = 16'd0;
				bc_n  = 4'd0;
				as_n  = 1'b1;
				st_n  = i2cm_pkg::ST_OK;
				ph_n  = i2cm_pkg::PH_START_SETUP;
				tk_n  = 16'd0;
			end
		end else if (phase_q == i2cm_pkg::PH_WAIT_DATA) begin
			if (cmd.write_byte_valid) begin
				taken = 1'b1;
				sh_n  = cmd.write_byte;
				ph_n  = i2cm_pkg::PH_BIT_LOW;
				tk_n  = 16'd0;
			end
		end else begin
			tk_n = tick_inc;
			if (tick_inc >= plen) begin
				tk_n = 16'd0;
				unique case (phase_q)
					i2cm_pkg::PH_START_SETUP: ph_n = i2cm_pkg::PH_START_HOLD;
					i2cm_pkg::PH_START_HOLD:  ph_n = i2cm_pkg::PH_BIT_LOW;
					i2cm_pkg::PH_BIT_LOW:     ph_n = i2cm_pkg::PH_BIT_HIGH;
					i2cm_pkg::PH_BIT_HIGH: begin
						sh_n = {shift_q[6:0], rx & cmd.sda_in};
						if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
							bc_n   = 4'd0;
							rvalid = rx;
							ph_n   = i2cm_pkg::PH_ACK_LOW;
						end else begin
							bc_n = bit_inc;
							ph_n = i2cm_pkg::PH_BIT_LOW;
						end
					end
					i2cm_pkg::PH_ACK_LOW: ph_n = i2cm_pkg::PH_ACK_HIGH;
					i2cm_pkg::PH_ACK_HIGH: begin
						if (addr_stage_q) begin
							if (cmd.sda_in) begin
								st_n = i2cm_pkg::ST_ADDR_NACK;
								ph_n = i2cm_pkg::PH_STOP_LOW;
							end else begin
								as_n = 1'b0;
								if (byte_q >= total_q) begin
									ph_n = i2cm_pkg::PH_STOP_LOW;
								end else if (is_read_q) begin
									ph_n = i2cm_pkg::PH_BIT_LOW;
								end else begin
									ph_n = i2cm_pkg::PH_WAIT_DATA;
								end
							end
						end else if (is_read_q) begin
							by_n = byte_inc;
							ph_n = (byte_inc >= total_q) ? i2cm_pkg::PH_STOP_LOW
							                             : i2cm_pkg::PH_BIT_LOW;
						end else if (cmd.sda_in) begin
							st_n = i2cm_pkg::ST_DATA_NACK;
							ph_n = i2cm_pkg::PH_STOP_LOW;
						end else begin
							by_n = byte_inc;
							ph_n = (byte_inc >= total_q) ? i2cm_pkg::PH_STOP_LOW
							                             : i2cm_pkg::PH_WAIT_DATA;
						end
					end
					i2cm_pkg::PH_STOP_LOW: ph_n = i2cm_pkg::PH_STOP_SETUP;
					default: begin
						done = 1'b1;
						ph_n = i2cm_pkg::PH_IDLE;
					end
				endcase
			end
		end

		// drive levels follow the state left by this step
		rx_n = rd_n && !as_n;
		bitv = rx_n ? 1'b1 : sh_n[7];
		ackb = 1'b1;
		if (rx_n) begin
			ackb = ({1'b0, by_n} + 17'd1 < {1'b0, tot_n}) ? 1'b0 : 1'b1;
		end
		unique case (ph_n)
			i2cm_pkg::PH_START_HOLD: begin
				res.scl_out = 1'b1; res.sda_out = 1'b0;
			end
			i2cm_pkg::PH_BIT_LOW: begin
				res.scl_out = 1'b0; res.sda_out = bitv;
			end
			i2cm_pkg::PH_BIT_HIGH: begin
				res.scl_out = 1'b1; res.sda_out = bitv;
			end
			i2cm_pkg::PH_ACK_LOW: begin
				res.scl_out = 1'b0; res.sda_out = ackb;
			end
			i2cm_pkg::PH_ACK_HIGH: begin
				res.scl_out = 1'b1; res.sda_out = ackb;
			end
			i2cm_pkg::PH_WAIT_DATA, i2cm_pkg::PH_STOP_LOW: begin
				res.scl_out = 1'b0; res.sda_out = 1'b0;
			end
			i2cm_pkg::PH_STOP_SETUP: begin
				res.scl_out = 1'b1; res.sda_out = 1'b0;
			end
			default: begin
				res.scl_out = 1'b1; res.sda_out = 1'b1;
			end
		endcase
		res.busy_res    = (ph_n != i2cm_pkg::PH_IDLE);
		res.write_taken = taken;
		res.read_byte   = rvalid ? sh_n : 8'd0;
		res.read_valid  = rvalid;
		res.done_res    = done;
		res.status      = done ? st_n : i2cm_pkg::ST_OK;
		res.nack_index  = (done && st_n == i2cm_pkg::ST_DATA_NACK) ? by_n : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q       <= i2cm_pkg::HOLD_TICKS_RST;
			high_q       <= i2cm_pkg::HIGH_TICKS_RST;
			low_q        <= i2cm_pkg::LOW_TICKS_RST;
			phase_q      <= i2cm_pkg::PH_IDLE;
			tick_q       <= '0;
			bit_q        <= '0;
			byte_q       <= '0;
			shift_q      <= '0;
			total_q      <= '0;
			is_read_q    <= 1'b0;
			addr_stage_q <= 1'b0;
			status_q     <= i2cm_pkg::ST_OK;
		end else begin
			if (cfg_wr.we) begin
				unique case (cfg_wr.index)
					i2cm_pkg::REG_HOLD_TICKS: hold_q <= cfg_wr.data;
					i2cm_pkg::REG_HIGH_TICKS: high_q <= cfg_wr.data;
					i2cm_pkg::REG_LOW_TICKS:  low_q  <= cfg_wr.data;
					default: ;
				endcase
			end
			if (step) begin
				phase_q      <= ph_n;
				tick_q       <= tk_n;
				bit_q        <= bc_n;
				byte_q       <= by_n;
				shift_q      <= sh_n;
				total_q      <= tot_n;
				is_read_q    <= rd_n;
				addr_stage_q <= as_n;
				status_q     <= st_n;
			end
		end
	end

endmodule

>>> sv/i2c_master_byte_engine.sv
// I2C master byte engine top level: command queue, bus sequencer, result queue.
//
// Each input beat is one timing tick of the bus. op selects a plain tick, the start of
// a write or the start of a read; address and length are latched at the start, and
// write_byte / write_byte_valid and sda_in are sampled on the ticks that need them.
// Every accepted beat yields exactly one result beat with the SCL/SDA drive levels,
// busy, write_taken, read_byte/read_valid and, on the tick that STOP completes,
// done_res with status and nack_index.
// Input: push/full. Output: empty/pop, the oldest result on the ports while empty is
// low. Tick registers are written through cfg_we/cfg_index/cfg_data, by the user only
// while idle; the block itself does not enforce this. Throughput: one beat per cycle
// while a command is queued and the result queue has room. A beat waits in the command
// queue, is stepped by the sequencer and its result is written into the result queue.
// Reset: both queues empty, sequencer idle, tick registers at 2, 1 and 1.
// A stalled receiver fills the result queue, the sequencer holds, the command queue
// fills and full rises; nothing is dropped.
module i2c_master_byte_engine #(
	parameter int CMD_DEPTH = i2cm_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH = i2cm_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [7:0]  address,
	input  logic [15:0] length,
	input  logic [7:0]  write_byte,
	input  logic        write_byte_valid,
	input  logic        sda_in,
	output logic        empty,
	input  logic        pop,
	output logic        scl_out,
	output logic        sda_out,
	output logic        busy_res,
	output logic        write_taken,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [15:0] nack_index,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	i2cm_pkg::cmd_t    cmd;
	i2cm_pkg::res_t    res_in;
	i2cm_pkg::res_t    res_out;
	i2cm_pkg::cfg_wr_t cfg_wr;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              res_push;
	logic              res_full;

	assign cfg_wr.we    = cfg_we;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	i2cm_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.op              (op),
		.address         (address),
		.length          (length),
		.write_byte      (write_byte),
		.write_byte_valid(write_byte_valid),
		.sda_in          (sda_in),
		.cmd_pop         (cmd_pop),
		.cmd             (cmd),
		.cmd_empty       (cmd_empty)
	);

	i2cm_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cmd      (cmd),
		.cmd_valid(!cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_ready(!res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	i2cm_fifo #(
		.WIDTH($bits(i2cm_pkg::res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.rd_en  (pop),
		.rd_data(res_out),
		.full   (res_full),
		.empty  (empty)
	);

	assign scl_out     = res_out.scl_out;
	assign sda_out     = res_out.sda_out;
	assign busy_res    = res_out.busy_res;
	assign write_taken = res_out.write_taken;
	assign read_byte   = res_out.read_byte;
	assign read_valid  = res_out.read_valid;
	assign done_res    = res_out.done_res;
	assign status      = res_out.status;
	assign nack_index  = res_out.nack_index;

	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!res_full && !cmd_empty))
		else $error("sequencer stepped without a command or without result room");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> !busy_res)
		else $error("STOP completed but engine still busy");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != i2cm_pkg::ST_OK) |-> done_res)
		else $error("status reported outside a done beat");

	a_take_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(write_taken && read_valid))
		else $error("write byte taken and read byte completed in one beat");

endmodule
